// ===== rtl/core/mcd_pkg.sv =====
// shared types and constants for the model chain discovery block
// used by mcd_walker, mcd_rfifo and model_chain_discovery
package mcd_pkg;

  localparam int unsigned MaxModelsDef = 32;
  localparam int unsigned MaxStepsDef  = 64;

  localparam int unsigned StepW  = 7;
  localparam int unsigned ModelW = 6;
  localparam int unsigned HdrW   = 17;

  localparam logic [15:0] MarkHi     = 16'h5375;
  localparam logic [15:0] MarkLo     = 16'h6E53;
  localparam logic [15:0] FirstBase  = 16'd40000;
  localparam logic [15:0] SecondBase = 16'd40001;
  localparam logic [17:0] SpaceEnd   = 18'h10000;
  localparam logic [15:0] EndId      = 16'hFFFF;
  localparam logic [7:0]  UnitReset  = 8'd1;

  typedef enum logic [1:0] {
    KIND_REQ = 2'd0,
    KIND_REC = 2'd1,
    KIND_RPT = 2'd2
  } mcd_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MARKER = 2'd1,
    PH_HEADER = 2'd2,
    PH_RETRY  = 2'd3
  } mcd_phase_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_RESP  = 1'b1
  } mcd_req_e;

  typedef struct packed {
    mcd_kind_e   kind;
    logic [7:0]  unit;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [15:0] id;
    logic        trunc;
    logic        ok;
    logic        last;
  } mcd_res_t;

  typedef struct packed {
    logic        req_type;
    logic        read_ok;
    logic [15:0] word_hi;
    logic [15:0] word_lo;
  } mcd_item_t;

endpackage

// ===== rtl/core/mcd_walker.sv =====
// walk state and per-beat step logic: up to two results per input beat
// depends on mcd_pkg
module mcd_walker #(
  parameter int unsigned MAX_MODELS = mcd_pkg::MaxModelsDef,
  parameter int unsigned MAX_STEPS  = mcd_pkg::MaxStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  mcd_pkg::mcd_item_t item_i,
  input  logic [7:0]        unit_i,
  output mcd_pkg::mcd_res_t res0_o,
  output mcd_pkg::mcd_res_t res1_o,
  output logic [1:0]        nres_o
);
  import mcd_pkg::*;

  mcd_phase_e         phase_q, phase_d;
  logic               tried_q, tried_d;
  logic [15:0]        base_q, base_d;
  logic [HdrW-1:0]    hdr_q, hdr_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [ModelW-1:0]  mcnt_q, mcnt_d;
  logic               trunc_q, trunc_d;

  logic [17:0]        span;
  logic [17:0]        after_next;
  logic [ModelW-1:0]  mcnt_inc;
  logic [StepW-1:0]   step_inc;
  logic [15:0]        hdr_base;

  function automatic mcd_res_t mk_req(logic [7:0] unit, logic [15:0] addr,
                                      logic [15:0] cnt);
    mcd_res_t r;
    r       = '0;
    r.kind  = KIND_REQ;
    r.unit  = unit;
    r.addr  = addr;
    r.cnt   = cnt;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic mcd_res_t mk_rpt(logic [15:0] base, logic [ModelW-1:0] cnt,
                                      logic tr);
    mcd_res_t r;
    r       = '0;
    r.kind  = KIND_RPT;
    r.addr  = base;
    r.cnt   = 16'(cnt);
    r.trunc = tr;
    r.ok    = (cnt != '0);
    r.last  = 1'b1;
    return r;
  endfunction

  always_comb begin
    span       = 18'(hdr_q) + 18'd2 + 18'(item_i.word_lo);
    after_next = span + 18'd2;
    mcnt_inc   = mcnt_q + ModelW'(1);
    step_inc   = step_q + StepW'(1);
    hdr_base   = tried_q ? SecondBase : FirstBase;
  end

  always_comb begin
    phase_d = phase_q;
    tried_d = tried_q;
    base_d  = base_q;
    hdr_d   = hdr_q;
    step_d  = step_q;
    mcnt_d  = mcnt_q;
    trunc_d = trunc_q;
    res0_o  = '0;
    res1_o  = '0;
    nres_o  = 2'd0;
    if (item_i.req_type == REQ_START) begin
      tried_d = 1'b0;
      base_d  = '0;
      hdr_d   = '0;
      step_d  = '0;
      mcnt_d  = '0;
      trunc_d = 1'b0;
      phase_d = PH_MARKER;
      res0_o  = mk_req(unit_i, FirstBase, 16'd2);
      nres_o  = 2'd1;
    end else begin
      case (phase_q)
        PH_MARKER: begin
          nres_o = 2'd1;
          if (item_i.read_ok && item_i.word_hi == MarkHi && item_i.word_lo == MarkLo) begin
            base_d  = hdr_base;
            hdr_d   = HdrW'(hdr_base) + HdrW'(2);
            step_d  = '0;
            phase_d = PH_HEADER;
            res0_o  = mk_req(unit_i, hdr_base + 16'd2, 16'd2);
          end else if (!tried_q) begin
            tried_d = 1'b1;
            res0_o  = mk_req(unit_i, SecondBase, 16'd2);
          end else begin
            base_d  = '0;
            phase_d = PH_IDLE;
            res0_o  = mk_rpt(16'd0, mcnt_q, trunc_q);
          end
        end
        PH_HEADER: begin
          nres_o = 2'd1;
          if (!item_i.read_ok) begin
            phase_d = PH_RETRY;
            res0_o  = mk_req(unit_i, hdr_q[15:0], 16'd1);
          end else if (item_i.word_hi == EndId) begin
            phase_d = PH_IDLE;
            res0_o  = mk_rpt(base_q, mcnt_q, trunc_q);
          end else if (item_i.word_lo == '0 || span > SpaceEnd ||
                       32'(mcnt_q) >= MAX_MODELS) begin
            trunc_d = 1'b1;
            phase_d = PH_IDLE;
            res0_o  = mk_rpt(base_q, mcnt_q, 1'b1);
          end else begin
            // record the model, then either finish or ask for the next header
            nres_o      = 2'd2;
            res0_o      = '0;
            res0_o.kind = KIND_REC;
            res0_o.addr = 16'(hdr_q + HdrW'(2));
            res0_o.cnt  = item_i.word_lo;
            res0_o.id   = item_i.word_hi;
            mcnt_d      = mcnt_inc;
            hdr_d       = span[HdrW-1:0];
            step_d      = step_inc;
            if (32'(step_inc) >= MAX_STEPS) begin
              phase_d = PH_IDLE;
              res1_o  = mk_rpt(base_q, mcnt_inc, trunc_q);
            end else if (after_next > SpaceEnd) begin
              trunc_d = 1'b1;
              phase_d = PH_IDLE;
              res1_o  = mk_rpt(base_q, mcnt_inc, 1'b1);
            end else begin
              res1_o  = mk_req(unit_i, span[15:0], 16'd2);
            end
          end
        end
        PH_RETRY: begin
          nres_o  = 2'd1;
          trunc_d = trunc_q | !(item_i.read_ok && item_i.word_hi == EndId);
          phase_d = PH_IDLE;
          res0_o  = mk_rpt(base_q, mcnt_q, trunc_d);
        end
        default: begin
          // response with no walk in progress is dropped
          nres_o = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tried_q <= 1'b0;
      base_q  <= '0;
      hdr_q   <= '0;
      step_q  <= '0;
      mcnt_q  <= '0;
      trunc_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tried_q <= tried_d;
      base_q  <= base_d;
      hdr_q   <= hdr_d;
      step_q  <= step_d;
      mcnt_q  <= mcnt_d;
      trunc_q <= trunc_d;
    end
  end

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && nres_o == 2'd2 |-> res0_o.kind == KIND_REC && !res0_o.last && res1_o.last)
    else $error("two-result beat not a record followed by a final result");

  a_report_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ((nres_o == 2'd1 && res0_o.kind == KIND_RPT) ||
               (nres_o == 2'd2 && res1_o.kind == KIND_RPT)) |=> phase_q == PH_IDLE)
    else $error("walk still active after final report");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mcnt_q) <= MAX_MODELS)
    else $error("model count past table size");

endmodule

// ===== rtl/core/mcd_rfifo.sv =====
// four-entry result queue, takes up to two results per cycle, gives one
// depends on mcd_pkg
module mcd_rfifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  mcd_pkg::mcd_res_t push0_i,
  input  mcd_pkg::mcd_res_t push1_i,
  input  logic              pop_i,
  output mcd_pkg::mcd_res_t head_o,
  output logic              nonempty_o,
  output logic              room2_o
);
  import mcd_pkg::*;

  localparam int unsigned Depth = 4;

  mcd_res_t   mem_q [Depth];
  logic [1:0] wp_q, wp_d;
  logic [1:0] rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop        = pop_i && (cnt_q != 3'd0);
  assign nonempty_o = (cnt_q != 3'd0);
  assign room2_o    = (cnt_q <= 3'd2);
  assign head_o     = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + push_n_i;
    rp_d  = rp_q + 2'(pop);
    cnt_d = cnt_q + 3'(push_n_i) - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wp_q + 2'd1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i != 2'd0 |-> 32'(cnt_q) + 32'(push_n_i) <= Depth)
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 3'd4 |-> (wp_q - rp_q) == cnt_q[1:0])
    else $error("queue pointers disagree with fill count");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_o && !pop_i |=> $stable(head_o))
    else $error("head result changed while held");

endmodule

// ===== rtl/core/model_chain_discovery.sv =====
// top level of the model chain discovery block: input register, walker, result queue
// depends on mcd_pkg, mcd_walker, mcd_rfifo
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-------------------------------
//   in       | in        | in_valid_i / in_stall_o   | req_type, read_ok, word_hi/lo
//   out      | out       | out_valid_o / out_stall_i | kind, unit, addr, count, id, flags
//   cfg      | in        | cfg_we_i                  | cfg_wdata_i (unit address)
//
// an input beat is registered, then processed by the walker,
// which pushes up to two results into a four-entry queue; the first result
// is valid once it is registered in the queue, which follows the input register.
// one input beat per cycle while the queue has room for two results; the
// single output port sets the rate to one result per cycle while out_stall_i is low.
// reset clears walk state and queue, the unit address returns to 1.
module model_chain_discovery #(
  parameter int unsigned MAX_MODELS = mcd_pkg::MaxModelsDef,
  parameter int unsigned MAX_STEPS  = mcd_pkg::MaxStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_req_type_i,
  input  logic        in_read_ok_i,
  input  logic [15:0] in_word_hi_i,
  input  logic [15:0] in_word_lo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_target_unit_o,
  output logic [15:0] out_reg_addr_o,
  output logic [15:0] out_reg_count_o,
  output logic [15:0] out_model_id_o,
  output logic        out_truncated_o,
  output logic        out_success_o,
  output logic        out_last_o
);
  import mcd_pkg::*;

  logic [7:0] unit_addr_q;
  mcd_item_t  item_q;
  logic       in_vld_q;
  logic       fire;
  logic       in_take;
  logic       room2;
  logic       nonempty;
  mcd_res_t   res0, res1, head;
  logic [1:0] nres;
  logic [1:0] push_n;

  assign fire       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;
  assign in_take    = in_valid_i && !in_stall_o;
  assign push_n     = fire ? nres : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_addr_q <= UnitReset;
    end else if (cfg_we_i) begin
      unit_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type <= in_req_type_i;
      item_q.read_ok  <= in_read_ok_i;
      item_q.word_hi  <= in_word_hi_i;
      item_q.word_lo  <= in_word_lo_i;
    end
  end

  mcd_walker #(
    .MAX_MODELS (MAX_MODELS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .unit_i (unit_addr_q),
    .res0_o (res0),
    .res1_o (res1),
    .nres_o (nres)
  );

  mcd_rfifo u_rfifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (!out_stall_i),
    .head_o     (head),
    .nonempty_o (nonempty),
    .room2_o    (room2)
  );

  assign out_valid_o       = nonempty;
  assign out_kind_o        = head.kind;
  assign out_target_unit_o = head.unit;
  assign out_reg_addr_o    = head.addr;
  assign out_reg_count_o   = head.cnt;
  assign out_model_id_o    = head.id;
  assign out_truncated_o   = head.trunc;
  assign out_success_o     = head.ok;
  assign out_last_o        = head.last;

endmodule
